FILE: design/rqd_pkg.sv
// Shared types, widths, register codes and reset values for the RED drop decider.
package rqd_pkg;

  localparam int unsigned QLEN_W     = 16;
  localparam int unsigned TICK_W     = 32;
  localparam int unsigned AVG_W      = 32;
  localparam int unsigned FRAC_W     = 16;
  localparam int unsigned PROB_W     = 16;
  localparam int unsigned SHIFT_W    = 4;
  localparam int unsigned CNT_W      = 17;
  localparam int unsigned CAUSE_W    = 2;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // Serial multiplier: 32-bit multiplicand, 16-bit multiplier.
  localparam int unsigned MUL_A_W = 32;
  localparam int unsigned MUL_B_W = 16;
  localparam int unsigned MUL_P_W = MUL_A_W + MUL_B_W;

  // Serial divider: 48-bit dividend, 32-bit divisor, 16-bit quotient.
  localparam int unsigned DIV_D_W = 32;
  localparam int unsigned DIV_Q_W = 16;
  localparam int unsigned DIV_N_W = DIV_D_W + DIV_Q_W;

  localparam int unsigned IDLE_LIMIT_DEF = 1024;

  localparam logic [SHIFT_W-1:0] WEIGHT_SHIFT_RST = 4'd9;
  localparam logic [QLEN_W-1:0]  MIN_TH_RST       = 16'd5;
  localparam logic [QLEN_W-1:0]  MAX_TH_RST       = 16'd15;
  localparam logic [PROB_W-1:0]  MAX_PROB_RST     = 16'd1311;
  localparam logic [PROB_W-1:0]  DROP_LEVEL_RST   = 16'd983;

  // Count runs from minus one up to a saturation value.
  localparam logic [CNT_W-1:0] CNT_MINUS_ONE = {CNT_W{1'b1}};
  localparam logic [CNT_W-1:0] CNT_MAX       = {1'b0, {(CNT_W-1){1'b1}}};

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WEIGHT_SHIFT = 3'd0,
    CFG_MIN_TH       = 3'd1,
    CFG_MAX_TH       = 3'd2,
    CFG_MAX_PROB     = 3'd3,
    CFG_DROP_LEVEL   = 3'd4
  } cfg_idx_e;

  localparam logic [CAUSE_W-1:0] CAUSE_NONE   = 2'd0;
  localparam logic [CAUSE_W-1:0] CAUSE_EARLY  = 2'd1;
  localparam logic [CAUSE_W-1:0] CAUSE_FORCED = 2'd2;

  typedef struct packed {
    logic [QLEN_W-1:0] queue_len;
    logic [TICK_W-1:0] now_tick;
  } rqd_in_t;

  typedef struct packed {
    logic               drop;
    logic [CAUSE_W-1:0] drop_cause;
    logic [AVG_W-1:0]   avg_queue;
  } rqd_out_t;

  typedef struct packed {
    logic              start;
    logic              track;
    logic [QLEN_W-1:0] queue_len;
  } avg_req_t;

  typedef struct packed {
    logic               start;
    logic [MUL_A_W-1:0] mcand;
    logic [MUL_B_W-1:0] mplier;
  } mul_req_t;

  typedef struct packed {
    logic               start;
    logic [DIV_N_W-1:0] dividend;
    logic [DIV_D_W-1:0] divisor;
  } div_req_t;

  typedef enum logic [1:0] {
    AVG_IDLE,
    AVG_STEP,
    AVG_DECAY
  } avg_state_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_AVG,
    ST_CMP,
    ST_MUL1,
    ST_DIV,
    ST_MUL2,
    ST_MUL3,
    ST_FIN
  } rqd_state_e;

endpackage

FILE: design/rqd_mul.sv
// Bit-serial shift-and-add multiplier, one multiplier bit per cycle.
module rqd_mul (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  rqd_pkg::mul_req_t               req_i,
  output logic                            done_o,
  output logic [rqd_pkg::MUL_P_W-1:0]     prod_o
);

  localparam int unsigned AW   = rqd_pkg::MUL_A_W;
  localparam int unsigned BW   = rqd_pkg::MUL_B_W;
  localparam int unsigned PW   = rqd_pkg::MUL_P_W;
  localparam int unsigned CntW = $clog2(BW + 1);

  logic [AW-1:0]   mcand_q;
  logic [PW-1:0]   prod_q, prod_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [AW:0]     sum;

  always_comb begin
    // add the multiplicand into the upper half when the low bit is set
    sum    = {1'b0, prod_q[PW-1:BW]} + (prod_q[0] ? {1'b0, mcand_q} : '0);
    prod_d = prod_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      prod_d = {{AW{1'b0}}, req_i.mplier};
      cnt_d  = CntW'(BW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      prod_d = {sum, prod_q[BW-1:1]};
      cnt_d  = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    if (req_i.start) begin
      mcand_q <= req_i.mcand;
    end
  end

  assign done_o = done_q;
  assign prod_o = prod_q;

endmodule

FILE: design/rqd_div.sv
// Restoring serial divider, one quotient bit per cycle; dividend must satisfy N < D * 2^16.
module rqd_div (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  rqd_pkg::div_req_t               req_i,
  output logic                            done_o,
  output logic [rqd_pkg::DIV_Q_W-1:0]     quo_o
);

  localparam int unsigned DW   = rqd_pkg::DIV_D_W;
  localparam int unsigned QW   = rqd_pkg::DIV_Q_W;
  localparam int unsigned NW   = rqd_pkg::DIV_N_W;
  localparam int unsigned CntW = $clog2(QW + 1);

  logic [DW-1:0]   rem_q, rem_d;
  logic [QW-1:0]   quo_q, quo_d;
  logic [DW-1:0]   dsr_q;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [DW:0]     trial, sub;
  logic            ge;

  always_comb begin
    // shift in the next dividend bit and try the subtract
    trial  = {rem_q, quo_q[QW-1]};
    sub    = trial - {1'b0, dsr_q};
    ge     = (trial >= {1'b0, dsr_q});
    rem_d  = rem_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      rem_d  = req_i.dividend[NW-1:QW];
      quo_d  = req_i.dividend[QW-1:0];
      cnt_d  = CntW'(QW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = ge ? sub[DW-1:0] : trial[DW-1:0];
      quo_d = {quo_q[QW-2:0], ge};
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    if (req_i.start) begin
      dsr_q <= req_i.divisor;
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

FILE: design/rqd_avg.sv
// Average queue length register with tracking update and iterative idle decay.
module rqd_avg #(
  parameter int unsigned IDLE_W = $clog2(rqd_pkg::IDLE_LIMIT_DEF + 1)
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  rqd_pkg::avg_req_t               req_i,
  input  logic [IDLE_W-1:0]               ticks_i,
  input  logic [rqd_pkg::SHIFT_W-1:0]     shift_i,
  output logic                            done_o,
  output logic [rqd_pkg::AVG_W-1:0]       avg_o
);

  localparam int unsigned AW = rqd_pkg::AVG_W;
  localparam int unsigned FW = rqd_pkg::FRAC_W;

  rqd_pkg::avg_state_e state_q, state_d;

  logic [AW-1:0]     avg_q, avg_d;
  logic [AW-1:0]     diff_q, diff_d;
  logic              up_q, up_d;
  logic [IDLE_W-1:0] ticks_q, ticks_d;
  logic [AW-1:0]     target;
  logic [FW:0]       round_mask;
  logic [AW:0]       ceil_sum;
  logic              decay_end;

  assign target     = {req_i.queue_len, {FW{1'b0}}};
  assign round_mask = ((FW+1)'(1) << shift_i) - (FW+1)'(1);
  assign ceil_sum   = {1'b0, diff_q} + {{(AW-FW){1'b0}}, round_mask};
  assign decay_end  = (ticks_q == '0) || (avg_q == '0);

  always_comb begin
    state_d = state_q;
    case (state_q)
      rqd_pkg::AVG_IDLE: begin
        if (req_i.start) begin
          state_d = req_i.track ? rqd_pkg::AVG_STEP : rqd_pkg::AVG_DECAY;
        end
      end
      rqd_pkg::AVG_STEP: begin
        state_d = rqd_pkg::AVG_IDLE;
      end
      rqd_pkg::AVG_DECAY: begin
        if (decay_end) begin
          state_d = rqd_pkg::AVG_IDLE;
        end
      end
      default: begin
        state_d = rqd_pkg::AVG_IDLE;
      end
    endcase
  end

  always_comb begin
    avg_d   = avg_q;
    diff_d  = diff_q;
    up_d    = up_q;
    ticks_d = ticks_q;
    done_o  = 1'b0;
    case (state_q)
      rqd_pkg::AVG_IDLE: begin
        // capture the distance to the target and the idle tick count
        if (req_i.start) begin
          up_d    = (target >= avg_q);
          diff_d  = (target >= avg_q) ? (target - avg_q) : (avg_q - target);
          ticks_d = ticks_i;
        end
      end
      rqd_pkg::AVG_STEP: begin
        // rising: truncate the step; falling: round the step up
        done_o = 1'b1;
        avg_d  = up_q ? (avg_q + (diff_q >> shift_i))
                      : (avg_q - AW'(ceil_sum >> shift_i));
      end
      rqd_pkg::AVG_DECAY: begin
        if (decay_end) begin
          done_o = 1'b1;
        end else begin
          avg_d   = avg_q - (avg_q >> shift_i);
          ticks_d = ticks_q - IDLE_W'(1);
        end
      end
      default: begin
        done_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rqd_pkg::AVG_IDLE;
      avg_q   <= '0;
      ticks_q <= '0;
    end else begin
      state_q <= state_d;
      avg_q   <= avg_d;
      ticks_q <= ticks_d;
    end
  end

  always_ff @(posedge clk_i) begin
    diff_q <= diff_d;
    up_q   <= up_d;
  end

  assign avg_o = avg_q;

endmodule

FILE: design/red_queue_drop_decider.sv
// Top level of the random early detection drop decider.
//
//   channel  direction  handshake                 transfer payload
//   in       input      in_valid_i / in_stall_o   rqd_in_t  (queue_len, now_tick)
//   out      output     out_valid_o / out_stall_i rqd_out_t (drop, drop_cause, avg_queue)
//   cfg      input      cfg_we_i                  cfg_idx_i, cfg_data_i
//
// One item at a time. Average update: a tracking step when the queue is
// non-empty, or one decay step per idle tick, up to IDLE_LIMIT, when it is empty
// (decay stops early once the average reaches zero). Outside the threshold band
// the compare state goes straight to the final state; inside the band the
// 16-step serial multiplier runs up to three times and the 16-step serial
// divider once. A finished result sits in the output register, so the next
// item can be taken while it waits under out_stall_i. Reset is asynchronous,
// active low, and puts control and config registers at their reset values.
module red_queue_drop_decider #(
  parameter int unsigned IDLE_LIMIT = rqd_pkg::IDLE_LIMIT_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  rqd_pkg::rqd_in_t                   in_data_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output rqd_pkg::rqd_out_t                  out_data_o,
  input  logic                               cfg_we_i,
  input  logic [rqd_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [rqd_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  localparam int unsigned IdleW = $clog2(IDLE_LIMIT + 1);
  localparam int unsigned TickW = rqd_pkg::TICK_W;
  localparam int unsigned AW    = rqd_pkg::AVG_W;
  localparam int unsigned FW    = rqd_pkg::FRAC_W;
  localparam int unsigned CW    = rqd_pkg::CNT_W;
  localparam int unsigned PW    = rqd_pkg::MUL_P_W;
  localparam int unsigned PBW   = rqd_pkg::PROB_W;
  localparam logic [TickW-1:0] IdleLimitTick = TickW'(IDLE_LIMIT);
  localparam logic [IdleW-1:0] IdleLimitCnt  = IdleW'(IDLE_LIMIT);

  // configuration registers
  logic [rqd_pkg::SHIFT_W-1:0] weight_shift_q;
  logic [rqd_pkg::QLEN_W-1:0]  min_th_q;
  logic [rqd_pkg::QLEN_W-1:0]  max_th_q;
  logic [PBW-1:0]              max_prob_q;
  logic [PBW-1:0]              drop_level_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      weight_shift_q <= rqd_pkg::WEIGHT_SHIFT_RST;
      min_th_q       <= rqd_pkg::MIN_TH_RST;
      max_th_q       <= rqd_pkg::MAX_TH_RST;
      max_prob_q     <= rqd_pkg::MAX_PROB_RST;
      drop_level_q   <= rqd_pkg::DROP_LEVEL_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        rqd_pkg::CFG_WEIGHT_SHIFT: weight_shift_q <= cfg_data_i[rqd_pkg::SHIFT_W-1:0];
        rqd_pkg::CFG_MIN_TH:       min_th_q       <= cfg_data_i;
        rqd_pkg::CFG_MAX_TH:       max_th_q       <= cfg_data_i;
        rqd_pkg::CFG_MAX_PROB:     max_prob_q     <= cfg_data_i;
        rqd_pkg::CFG_DROP_LEVEL:   drop_level_q   <= cfg_data_i;
        default: begin
          // unused index: ignore the write
        end
      endcase
    end
  end

  // control state and working registers
  rqd_pkg::rqd_state_e state_q, state_d;

  logic [TickW-1:0]           idle_since_q;
  logic [CW-1:0]              count_q, count_d;
  logic [PBW-1:0]             pb_q, pb_d;
  logic                       drop_q, drop_d;
  logic [rqd_pkg::CAUSE_W-1:0] cause_q, cause_d;
  logic                       out_valid_q, out_valid_d;
  rqd_pkg::rqd_out_t          out_data_q, out_data_d;
  logic                       out_load;

  logic                       in_accept;
  logic [TickW-1:0]           elapsed;
  logic [IdleW-1:0]           idle_ticks;

  rqd_pkg::avg_req_t          avg_req;
  rqd_pkg::mul_req_t          mul_req;
  rqd_pkg::div_req_t          div_req;
  logic                       avg_done, mul_done, div_done;
  logic [AW-1:0]              avg_val;
  logic [PW-1:0]              mul_prod;
  logic [rqd_pkg::DIV_Q_W-1:0] div_quo;

  logic [AW-1:0]              lo_th, hi_th;
  logic                       forced, below;
  logic [CW-1:0]              count_inc;
  logic                       cp_big;
  logic                       pa_hit;

  assign in_stall_o = (state_q != rqd_pkg::ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;

  // saturate the idle tick count; the subtraction wraps with the tick counter
  assign elapsed    = in_data_i.now_tick - idle_since_q;
  assign idle_ticks = (elapsed > IdleLimitTick) ? IdleLimitCnt : elapsed[IdleW-1:0];

  assign lo_th     = {min_th_q, {FW{1'b0}}};
  assign hi_th     = {max_th_q, {FW{1'b0}}};
  assign forced    = (avg_val >= hi_th);
  assign below     = (avg_val < lo_th);
  assign count_inc = (count_q == rqd_pkg::CNT_MAX) ? count_q : count_q + CW'(1);
  // count * pb of at least one: drop without forming pa
  assign cp_big    = |mul_prod[PW-1:FW];
  // pa >= drop_level  <=>  pb << 16 >= drop_level * (65536 - count*pb)
  assign pa_hit    = (mul_prod <= {{(PW-PBW-FW){1'b0}}, pb_q, {FW{1'b0}}});

  rqd_avg #(
    .IDLE_W (IdleW)
  ) u_avg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (avg_req),
    .ticks_i (idle_ticks),
    .shift_i (weight_shift_q),
    .done_o  (avg_done),
    .avg_o   (avg_val)
  );

  rqd_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .done_o (mul_done),
    .prod_o (mul_prod)
  );

  rqd_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .done_o (div_done),
    .quo_o  (div_quo)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      rqd_pkg::ST_IDLE: begin
        if (in_accept) begin
          state_d = rqd_pkg::ST_AVG;
        end
      end
      rqd_pkg::ST_AVG: begin
        if (avg_done) begin
          state_d = rqd_pkg::ST_CMP;
        end
      end
      rqd_pkg::ST_CMP: begin
        state_d = (forced || below) ? rqd_pkg::ST_FIN : rqd_pkg::ST_MUL1;
      end
      rqd_pkg::ST_MUL1: begin
        if (mul_done) begin
          state_d = rqd_pkg::ST_DIV;
        end
      end
      rqd_pkg::ST_DIV: begin
        if (div_done) begin
          state_d = rqd_pkg::ST_MUL2;
        end
      end
      rqd_pkg::ST_MUL2: begin
        if (mul_done) begin
          state_d = cp_big ? rqd_pkg::ST_FIN : rqd_pkg::ST_MUL3;
        end
      end
      rqd_pkg::ST_MUL3: begin
        if (mul_done) begin
          state_d = rqd_pkg::ST_FIN;
        end
      end
      rqd_pkg::ST_FIN: begin
        if (out_load) begin
          state_d = rqd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = rqd_pkg::ST_IDLE;
      end
    endcase
  end

  // datapath control and unit launches
  always_comb begin
    avg_req  = '0;
    mul_req  = '0;
    div_req  = '0;
    count_d  = count_q;
    pb_d     = pb_q;
    drop_d   = drop_q;
    cause_d  = cause_q;
    out_load = 1'b0;
    case (state_q)
      rqd_pkg::ST_IDLE: begin
        avg_req.start     = in_accept;
        avg_req.track     = (in_data_i.queue_len != '0);
        avg_req.queue_len = in_data_i.queue_len;
      end
      rqd_pkg::ST_CMP: begin
        drop_d  = 1'b0;
        cause_d = rqd_pkg::CAUSE_NONE;
        if (forced) begin
          drop_d  = 1'b1;
          cause_d = rqd_pkg::CAUSE_FORCED;
          count_d = '0;
        end else if (below) begin
          count_d = rqd_pkg::CNT_MINUS_ONE;
        end else begin
          // in the band: pb numerator is max_prob * (avg - min)
          count_d        = count_inc;
          mul_req.start  = 1'b1;
          mul_req.mcand  = avg_val - lo_th;
          mul_req.mplier = max_prob_q;
        end
      end
      rqd_pkg::ST_MUL1: begin
        if (mul_done) begin
          div_req.start    = 1'b1;
          div_req.dividend = mul_prod;
          div_req.divisor  = hi_th - lo_th;
        end
      end
      rqd_pkg::ST_DIV: begin
        if (div_done) begin
          pb_d           = div_quo;
          mul_req.start  = 1'b1;
          mul_req.mcand  = {{(AW-CW+1){1'b0}}, count_q[CW-2:0]};
          mul_req.mplier = div_quo;
        end
      end
      rqd_pkg::ST_MUL2: begin
        if (mul_done) begin
          if (cp_big) begin
            drop_d  = 1'b1;
            cause_d = rqd_pkg::CAUSE_EARLY;
            count_d = '0;
          end else begin
            mul_req.start  = 1'b1;
            mul_req.mcand  = {{(AW-FW-1){1'b0}},
                              {1'b1, {FW{1'b0}}} - {1'b0, mul_prod[FW-1:0]}};
            mul_req.mplier = drop_level_q;
          end
        end
      end
      rqd_pkg::ST_MUL3: begin
        if (mul_done && pa_hit) begin
          drop_d  = 1'b1;
          cause_d = rqd_pkg::CAUSE_EARLY;
          count_d = '0;
        end
      end
      rqd_pkg::ST_FIN: begin
        // hand the result over once the output register is free
        out_load = !out_valid_q || !out_stall_i;
      end
      default: begin
        out_load = 1'b0;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (out_load) begin
      out_valid_d          = 1'b1;
      out_data_d.drop      = drop_q;
      out_data_d.drop_cause = cause_q;
      out_data_d.avg_queue = avg_val;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= rqd_pkg::ST_IDLE;
      count_q      <= rqd_pkg::CNT_MINUS_ONE;
      idle_since_q <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      // an empty-queue arrival restarts the idle interval
      if (in_accept && (in_data_i.queue_len == '0)) begin
        idle_since_q <= in_data_i.now_tick;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pb_q       <= pb_d;
    drop_q     <= drop_d;
    cause_q    <= cause_d;
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // drop flag and cause code agree on every result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.drop == (out_data_o.drop_cause != rqd_pkg::CAUSE_NONE)))
    else $error("drop flag and drop cause disagree");

  // a freshly loaded drop leaves the count at zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($rose(out_valid_o) && out_data_o.drop) |-> (count_q == '0))
    else $error("count not cleared on drop");

  // divider launched only with a quotient that fits its width
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req.start |-> (div_req.dividend[PW-1:FW] < div_req.divisor))
    else $error("divider operands out of range");

  // a result is loaded only from the final state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> ($past(state_q) == rqd_pkg::ST_FIN))
    else $error("result loaded outside the final state");

endmodule
